// ----- sv/mrc_pkg.sv -----
// Shared types, codes and the CRC-16 byte function of the Modbus RTU response checker.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int unsigned TimeoutW  = 16;
    localparam int unsigned PosW      = 17;
    localparam int unsigned InDataW   = 56;
    localparam int unsigned OutDataW  = 32;
    localparam int unsigned CfgIndexW = 1;

    localparam logic [TimeoutW-1:0] FIRST_TIMEOUT_RST = 16'd10000;
    localparam logic [TimeoutW-1:0] GAP_TIMEOUT_RST   = 16'd35;

    // input request kinds
    localparam logic [1:0] KIND_ARM  = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // request operations
    localparam logic [1:0] OP_READ_HOLD   = 2'd0;
    localparam logic [1:0] OP_WRITE_ONE   = 2'd1;
    localparam logic [1:0] OP_WRITE_MULTI = 2'd2;

    // Modbus function codes
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_WRITE_ONE   = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI = 8'd16;

    // completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_CRC      = 3'd2;
    localparam logic [2:0] ST_ADDRESS  = 3'd3;
    localparam logic [2:0] ST_FUNCTION = 3'd4;
    localparam logic [2:0] ST_COUNT    = 3'd5;
    localparam logic [2:0] ST_ECHO     = 3'd6;

    // error flag bit positions
    localparam int unsigned ERR_ADDR  = 0;
    localparam int unsigned ERR_FUNC  = 1;
    localparam int unsigned ERR_COUNT = 2;
    localparam int unsigned ERR_ECHO  = 3;

    // config register indexes
    localparam logic [CfgIndexW-1:0] CFG_FIRST_TIMEOUT = 1'd0;
    localparam logic [CfgIndexW-1:0] CFG_GAP_TIMEOUT   = 1'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic       OUT_VALUE  = 1'b0;
    localparam logic       OUT_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  request_op;
        logic [7:0]  slave_id;
        logic [15:0] reg_address;
        logic [15:0] count_or_value;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic        out_kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic        last;
    } t_result;

    // reflected CRC-16, one byte, eight unrolled shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] fcode_of_op(input logic [1:0] op);
        logic [7:0] f;
        case (op)
            OP_READ_HOLD: f = FC_READ_HOLD;
            OP_WRITE_ONE: f = FC_WRITE_ONE;
            default:      f = FC_WRITE_MULTI;
        endcase
        return f;
    endfunction

endpackage

// ----- sv/mrc_core.sv -----
// Transaction state and per-request check logic of the Modbus RTU response checker.
`timescale 1ns / 1ps

module mrc_core
    import mrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_item               i_item,
    input  logic [TimeoutW-1:0] i_first_timeout,
    input  logic [TimeoutW-1:0] i_gap_timeout,
    output logic                o_res_valid,
    output t_result             o_res
);

    logic                r_busy, n_busy;
    logic [1:0]          r_op, n_op;
    logic [7:0]          r_slave, n_slave;
    logic [15:0]         r_addr, n_addr;
    logic [15:0]         r_count, n_count;
    logic [PosW-1:0]     r_pos, n_pos;
    // one bit above the position: 5+2n runs past 17 bits for the largest counts
    logic [PosW:0]       r_exp, n_exp;
    logic [15:0]         r_crc, n_crc;
    logic [7:0]          r_hold, n_hold;
    logic [15:0]         r_echo, n_echo;
    logic [3:0]          r_err, n_err;
    logic [TimeoutW-1:0] r_idle, n_idle;
    logic                r_seen, n_seen;

    logic [PosW:0]       pos_inc;
    logic [PosW:0]       data_end;
    logic [PosW-1:0]     data_ofs;
    logic [PosW-1:0]     byte_cnt_exp;
    logic [TimeoutW-1:0] limit;

    always_comb begin
        pos_inc      = {1'b0, r_pos} + {{PosW{1'b0}}, 1'b1};
        data_end     = r_exp - {{(PosW-1){1'b0}}, 2'd2};
        data_ofs     = r_pos - {{(PosW-2){1'b0}}, 2'd3};
        byte_cnt_exp = {r_count, 1'b0};
        limit        = r_seen ? i_gap_timeout : i_first_timeout;
    end

    always_comb begin
        n_busy  = r_busy;
        n_op    = r_op;
        n_slave = r_slave;
        n_addr  = r_addr;
        n_count = r_count;
        n_pos   = r_pos;
        n_exp   = r_exp;
        n_crc   = r_crc;
        n_hold  = r_hold;
        n_echo  = r_echo;
        n_err   = r_err;
        n_idle  = r_idle;
        n_seen  = r_seen;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_en) begin
            unique case (i_item.kind)
                KIND_ARM: begin
                    if (i_item.request_op <= OP_WRITE_MULTI) begin
                        n_busy  = 1'b1;
                        n_op    = i_item.request_op;
                        n_slave = i_item.slave_id;
                        n_addr  = i_item.reg_address;
                        n_count = i_item.count_or_value;
                        n_pos   = '0;
                        n_exp   = (i_item.request_op == OP_READ_HOLD)
                                  ? ({1'b0, i_item.count_or_value, 1'b0} + 18'd5) : 18'd8;
                        n_crc   = CRC_INIT;
                        n_hold  = '0;
                        n_echo  = '0;
                        n_err   = '0;
                        n_idle  = '0;
                        n_seen  = 1'b0;
                    end
                end
                KIND_BYTE: begin
                    if (r_busy) begin
                        n_crc  = crc16_byte(r_crc, i_item.rx_byte);
                        n_idle = '0;
                        n_seen = 1'b1;
                        if (r_pos == 17'd0) begin
                            if (i_item.rx_byte != r_slave) n_err[ERR_ADDR] = 1'b1;
                        end else if (r_pos == 17'd1) begin
                            if (i_item.rx_byte != fcode_of_op(r_op)) n_err[ERR_FUNC] = 1'b1;
                        end else if (r_op == OP_READ_HOLD) begin
                            if (r_pos == 17'd2) begin
                                if ({9'd0, i_item.rx_byte} != byte_cnt_exp)
                                    n_err[ERR_COUNT] = 1'b1;
                            end else if ({1'b0, r_pos} < data_end) begin
                                if (!data_ofs[0]) begin
                                    n_hold = i_item.rx_byte;
                                end else begin
                                    o_res_valid     = 1'b1;
                                    o_res.out_kind  = OUT_VALUE;
                                    o_res.reg_index = data_ofs[7:1];
                                    o_res.reg_value = {r_hold, i_item.rx_byte};
                                end
                            end
                        end else if (r_pos >= 17'd2 && r_pos <= 17'd5) begin
                            n_echo = {r_echo[7:0], i_item.rx_byte};
                            if (r_pos == 17'd3 && n_echo != r_addr) n_err[ERR_ECHO] = 1'b1;
                            if (r_pos == 17'd5 && n_echo != r_count) n_err[ERR_ECHO] = 1'b1;
                        end

                        n_pos = pos_inc[PosW-1:0];
                        if (pos_inc >= r_exp) begin
                            n_busy          = 1'b0;
                            o_res_valid     = 1'b1;
                            o_res           = '0;
                            o_res.out_kind  = OUT_STATUS;
                            o_res.last      = 1'b1;
                            if (n_crc != 16'd0)       o_res.status = ST_CRC;
                            else if (n_err[ERR_ADDR]) o_res.status = ST_ADDRESS;
                            else if (n_err[ERR_FUNC]) o_res.status = ST_FUNCTION;
                            else if (n_err[ERR_COUNT]) o_res.status = ST_COUNT;
                            else if (n_err[ERR_ECHO]) o_res.status = ST_ECHO;
                            else                      o_res.status = ST_OK;
                        end
                    end
                end
                KIND_TICK: begin
                    if (r_busy) begin
                        n_idle = (r_idle == 16'hFFFF) ? r_idle : (r_idle + 16'd1);
                        if (n_idle >= limit) begin
                            n_busy         = 1'b0;
                            o_res_valid    = 1'b1;
                            o_res.out_kind = OUT_STATUS;
                            o_res.status   = ST_TIMEOUT;
                            o_res.last     = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_seen <= n_seen;
        end
        r_op    <= n_op;
        r_slave <= n_slave;
        r_addr  <= n_addr;
        r_count <= n_count;
        r_pos   <= n_pos;
        r_exp   <= n_exp;
        r_crc   <= n_crc;
        r_hold  <= n_hold;
        r_echo  <= n_echo;
        r_err   <= n_err;
        r_idle  <= n_idle;
    end

`ifndef SYNTHESIS
    // register values only come out of a running read
    a_value_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.out_kind == OUT_VALUE) |-> (r_busy && r_op == OP_READ_HOLD))
        else $error("value item outside a read");

    // every status item closes the transaction
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.out_kind == OUT_STATUS) |=> !r_busy)
        else $error("busy after status item");

    // byte position stays inside the expected frame while running
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_pos} < r_exp))
        else $error("byte position past frame end");
`endif

endmodule

// ----- sv/modbus_rtu_response_checker.sv -----
// Top level of the Modbus RTU master response checker: stream ports, config, result register.
`timescale 1ns / 1ps

// Modbus RTU master response checker.
// Slave stream s_axis: tuser carries the kind (arm, rx byte, timer tick); tdata carries
// the request fields of an arm and the received byte. Send one arm request after each
// Modbus request goes out, then every received byte and every timer tick.
// Master stream m_axis: register value items (tuser 0) as each read word completes,
// then one completion status item (tuser 1, tlast 1) ending the transaction. Discard
// the values unless that status is ok.
// Config: i_cfg_we / i_cfg_index / i_cfg_data write the first-byte timeout (index 0)
// and the inter-byte gap timeout (index 1), in ticks; write only while idle.
// Throughput: one request per cycle unless m_axis stalls. The CRC-16 update and all field checks
// are one unrolled pass between the input register and the result register.
// Path: a request is registered in the input register, then its result, if any, in the result register.
// Stall: while m_axis_tready is low the result register holds and the input register
// holds one more request; s_axis_tready drops once both are full.
// Reset (synchronous, active low): both stages empty, no transaction armed,
// timeouts back to 10000 and 35 ticks.

module modbus_rtu_response_checker
    import mrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [1:0] request_op, [9:2] slave_id, [25:10] reg_address,
    // [41:26] count_or_value, [49:42] rx_byte, [55:50] zero
    input  logic [InDataW-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]           s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [6:0] reg_index, [22:7] reg_value, [25:23] status, [31:26] zero
    output logic [OutDataW-1:0]  m_axis_tdata,
    // [0] out_kind
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [TimeoutW-1:0]  i_cfg_data
);

    logic                r_in_valid;
    t_item               r_in, n_in;
    logic                r_out_valid, n_out_valid;
    t_result             r_out;
    logic [TimeoutW-1:0] r_first_to;
    logic [TimeoutW-1:0] r_gap_to;

    logic                advance;
    logic                res_valid;
    t_result             res;

    // input stage moves on when the result register is empty or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_in.kind           = s_axis_tuser;
        n_in.request_op     = s_axis_tdata[1:0];
        n_in.slave_id       = s_axis_tdata[9:2];
        n_in.reg_address    = s_axis_tdata[25:10];
        n_in.count_or_value = s_axis_tdata[41:26];
        n_in.rx_byte        = s_axis_tdata[49:42];
    end

    always_comb begin
        if (advance)
            n_out_valid = res_valid;
        else if (m_axis_tready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_first_to  <= FIRST_TIMEOUT_RST;
            r_gap_to    <= GAP_TIMEOUT_RST;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIRST_TIMEOUT: r_first_to <= i_cfg_data;
                    CFG_GAP_TIMEOUT:   r_gap_to   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (s_axis_tready && s_axis_tvalid)
            r_in <= n_in;
        if (advance && res_valid)
            r_out <= res;
    end

    mrc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_item          (r_in),
        .i_first_timeout (r_first_to),
        .i_gap_timeout   (r_gap_to),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.reg_value, r_out.reg_index};
    assign m_axis_tuser  = r_out.out_kind;
    assign m_axis_tlast  = r_out.last;

`ifndef SYNTHESIS
    // a held request is not overwritten while the core is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register overwritten");

    // tlast marks exactly the status items
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and out_kind disagree");

    // value items carry an ok status field
    a_value_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == OUT_VALUE) |-> (r_out.status == ST_OK))
        else $error("value item with nonzero status");
`endif

endmodule
